FILE: rtl/givens_rotation_unit_macros.svh
// assertion helpers for the givens rotation unit
`ifndef GIVENS_ROTATION_UNIT_MACROS_SVH
`define GIVENS_ROTATION_UNIT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while reset is low
`define GRU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("givens_rotation_unit assertion failed");

// next-cycle implication
`define GRU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("givens_rotation_unit assertion failed");

`endif

FILE: rtl/gru_pkg.sv
`default_nettype none

package gru_pkg;

    // status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_stat;

endpackage

`default_nettype wire

FILE: rtl/gru_mul.sv
`default_nettype none

module gru_mul #(
    parameter int MW = 32
) (
    input  logic                   i_clk,
    input  logic signed [MW-1:0]   i_a,
    input  logic signed [MW-1:0]   i_b,
    output logic signed [2*MW-1:0] o_prod
);

    logic signed [2*MW-1:0] r_prod;

    // one registered product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: rtl/gru_sqrt.sv
`default_nettype none

module gru_sqrt #(
    parameter int DW = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2*DW-1:0]       i_radicand,
    output logic [DW-1:0]         o_root,
    output gru_pkg::t_iter_stat   o_stat
);

    import gru_pkg::*;

    localparam int RW   = DW + 2;
    localparam int SW   = DW + 4;
    localparam int CNTW = $clog2(DW);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [2*DW-1:0] r_rad, n_rad;
    logic [RW-1:0]   r_rem, n_rem;
    logic [DW-1:0]   r_root, n_root;
    logic [SW-1:0]   w_shift;
    logic [SW-1:0]   w_trial;
    logic            w_round;

    // two radicand bits per step, one root bit per step
    assign w_shift = {r_rem, r_rad[2*DW-1:2*DW-2]};
    assign w_trial = {RW'(r_root), 2'b01};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (r_busy) begin
            n_rad = {r_rad[2*DW-3:0], 2'b00};
            if (w_shift >= w_trial) begin
                n_rem  = RW'(w_shift - w_trial);
                n_root = {r_root[DW-2:0], 1'b1};
            end else begin
                n_rem  = RW'(w_shift);
                n_root = {r_root[DW-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNTW'(DW - 1);
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    // round to nearest: remainder above the floor root
    assign w_round     = r_rem > RW'(r_root);
    assign o_root      = r_root + DW'(w_round);
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

FILE: rtl/gru_div.sv
`default_nettype none

module gru_div #(
    parameter int DW = 32,
    parameter int CF = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DW-1:0]         i_mag,
    input  logic [DW-1:0]         i_divisor,
    output logic [CF:0]           o_quot,
    output gru_pkg::t_iter_stat   o_stat
);

    import gru_pkg::*;

    localparam int NW   = DW + CF + 1;
    localparam int CNTW = $clog2(CF + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [DW-1:0]   r_rem, n_rem;
    logic [CF:0]     r_low, n_low;
    logic [CF:0]     r_quot, n_quot;
    logic [DW-1:0]   r_div, n_div;
    logic [NW-1:0]   w_num;
    logic [DW:0]     w_part;
    logic            w_fit;

    // rounded numerator: mag * 2^CF + divisor / 2
    assign w_num  = {1'b0, i_mag, {CF{1'b0}}} + NW'(i_divisor >> 1);
    assign w_part = {r_rem, r_low[CF]};
    assign w_fit  = w_part >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        n_quot = r_quot;
        n_div  = r_div;
        if (r_busy) begin
            n_low  = {r_low[CF-1:0], 1'b0};
            n_quot = {r_quot[CF-1:0], w_fit};
            if (w_fit) begin
                n_rem = DW'(w_part - {1'b0, r_div});
            end else begin
                n_rem = DW'(w_part);
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end else if (i_start) begin
            // quotient stays below 2^(CF+1), so the top bits start below the divisor
            n_busy = 1'b1;
            n_cnt  = CNTW'(CF);
            n_rem  = w_num[NW-1:CF+1];
            n_low  = w_num[CF:0];
            n_quot = '0;
            n_div  = i_divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_quot <= n_quot;
        r_div  <= n_div;
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

FILE: rtl/givens_rotation_unit.sv
// channel  direction  handshake                  payload
// in       sink       i_in_valid / o_in_ready    i_action, i_first_value, i_second_value
// out      source     o_out_valid / i_out_ready  o_first_result, o_second_result,
//                                                o_degenerate, o_saturated
//
// rotate or zero-pair set-up: the result passes five multiplier slots, then the output register
// set-up beat: the result also waits for the bit-serial square root and the two bit-serial
//   divisions sharing one divider
// one beat at a time: o_in_ready is low from accept until the result beat is taken
// a stalled result holds its payload; i_rst_n (synchronous) restores the identity rotation
`default_nettype none

module givens_rotation_unit #(
    parameter int DATA_WIDTH     = 32,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_action,
    input  logic signed [DATA_WIDTH-1:0] i_first_value,
    input  logic signed [DATA_WIDTH-1:0] i_second_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_first_result,
    output logic signed [DATA_WIDTH-1:0] o_second_result,
    output logic                         o_degenerate,
    output logic                         o_saturated
);

    import gru_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int CF = COEF_FRAC_BITS;
    localparam int CW = CF + 2;               // signed Q1.CF coefficient
    localparam int MW = (DW > CW) ? DW : CW;  // multiplier operand width
    localparam int PW = 2 * MW + 2;           // sum-of-products width

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL     = 4'd1;
    localparam logic [3:0] S_SQ_GO   = 4'd2;
    localparam logic [3:0] S_SQ_WAIT = 4'd3;
    localparam logic [3:0] S_DC_GO   = 4'd4;
    localparam logic [3:0] S_DC_WAIT = 4'd5;
    localparam logic [3:0] S_DS_GO   = 4'd6;
    localparam logic [3:0] S_DS_WAIT = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    localparam logic [2:0] K_LAST = 3'd4;
    localparam logic [PW-1:0] HALF_LSB = PW'(1) << (CF - 1);
    localparam logic [PW-1:0] NEG_LIM  = PW'(1) << (DW - 1);
    localparam logic [PW-1:0] POS_LIM  = NEG_LIM - PW'(1);
    localparam logic [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};

    // shift a sum of products down by CF with rounding, clip to the data range
    // returns {clipped, value}
    function automatic logic [DW:0] scale_out(input logic signed [PW-1:0] t);
        logic          neg;
        logic [PW-1:0] mag;
        logic [PW-1:0] rnd;
        neg = t[PW-1];
        mag = neg ? PW'(-t) : PW'(t);
        rnd = (mag + HALF_LSB) >> CF;
        if (neg) begin
            if (rnd > NEG_LIM) begin
                scale_out = {1'b1, 1'b1, {(DW-1){1'b0}}};
            end else begin
                scale_out = {1'b0, DW'(-rnd)};
            end
        end else begin
            if (rnd > POS_LIM) begin
                scale_out = {1'b1, DATA_MAX};
            end else begin
                scale_out = {1'b0, DW'(rnd)};
            end
        end
    endfunction

    logic [3:0]            r_state, n_state;
    logic [2:0]            r_k, n_k;
    logic                  r_action;
    logic signed [DW-1:0]  r_p, r_q;
    logic signed [CW-1:0]  r_cos, r_sin;
    logic signed [PW-1:0]  r_acc, r_t0;
    logic [DW-1:0]         r_h;
    logic                  r_out_valid;
    logic signed [DW-1:0]  r_first, r_second;
    logic                  r_degen, r_sat;

    logic signed [MW-1:0]   w_mul_a, w_mul_b;
    logic signed [2*MW-1:0] w_prod;
    logic signed [PW-1:0]   w_prod_ext;
    logic                   w_zero_pair;
    logic                   w_accept;
    logic                   w_sq_start, w_div_start;
    logic [DW-1:0]          w_root;
    logic [CF:0]            w_quot;
    logic [DW-1:0]          w_div_mag;
    logic [DW-1:0]          w_mag_p, w_mag_q;
    logic signed [CW-1:0]   w_coef_c, w_coef_s;
    logic [DW:0]            w_scale0, w_scale1;
    t_iter_stat             w_sq_stat, w_div_stat;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_zero_pair = (r_p == '0) && (r_q == '0);
    assign w_prod_ext  = PW'(w_prod);
    assign w_mag_p     = r_p[DW-1] ? DW'(-r_p) : DW'(r_p);
    assign w_mag_q     = r_q[DW-1] ? DW'(-r_q) : DW'(r_q);

    // operand schedule: set-up squares p and q, rotate forms c*p, s*q, c*q, s*p
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_k)
            3'd0: begin
                w_mul_a = r_action ? MW'(r_cos) : MW'(r_p);
                w_mul_b = MW'(r_p);
            end
            3'd1: begin
                w_mul_a = r_action ? MW'(r_sin) : MW'(r_q);
                w_mul_b = MW'(r_q);
            end
            3'd2: begin
                w_mul_a = r_action ? MW'(r_cos) : '0;
                w_mul_b = r_action ? MW'(r_q) : '0;
            end
            3'd3: begin
                w_mul_a = r_action ? MW'(r_sin) : '0;
                w_mul_b = r_action ? MW'(r_p) : '0;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    gru_mul #(.MW(MW)) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // sum of squares sits in r_t0 after the product phase
    gru_sqrt #(.DW(DW)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (r_t0[2*DW-1:0]),
        .o_root     (w_root),
        .o_stat     (w_sq_stat)
    );

    // one divider serves the cosine and then the sine
    assign w_div_mag = (r_state == S_DS_GO) ? w_mag_q : w_mag_p;

    gru_div #(.DW(DW), .CF(CF)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_mag     (w_div_mag),
        .i_divisor (r_h),
        .o_quot    (w_quot),
        .o_stat    (w_div_stat)
    );

    assign w_sq_start  = (r_state == S_SQ_GO) && !w_sq_stat.busy;
    assign w_div_start = ((r_state == S_DC_GO) || (r_state == S_DS_GO)) && !w_div_stat.busy;

    // apply the sign of the source element to the quotient
    assign w_coef_c = r_p[DW-1] ? -CW'(w_quot) : CW'(w_quot);
    assign w_coef_s = r_q[DW-1] ? -CW'(w_quot) : CW'(w_quot);

    assign w_scale0 = scale_out(r_t0);
    assign w_scale1 = scale_out(r_acc);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL;
                    n_k     = '0;
                end
            end
            S_MUL: begin
                n_k = r_k + 1'b1;
                if (r_k == K_LAST) begin
                    if (r_action || w_zero_pair) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SQ_GO;
                    end
                end
            end
            S_SQ_GO: begin
                if (w_sq_stat.busy) begin
                    n_state = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT: begin
                if (w_sq_stat.done) begin
                    n_state = S_DC_GO;
                end
            end
            S_DC_GO: begin
                if (w_div_stat.busy) begin
                    n_state = S_DC_WAIT;
                end
            end
            S_DC_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = S_DS_GO;
                end
            end
            S_DS_GO: begin
                if (w_div_stat.busy) begin
                    n_state = S_DS_WAIT;
                end
            end
            S_DS_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_cos       <= CW'(1) <<< CF;   // identity rotation
            r_sin       <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;

            if (r_state == S_DONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // zero pair restores the identity rotation
            if ((r_state == S_MUL) && (r_k == K_LAST) && !r_action && w_zero_pair) begin
                r_cos <= CW'(1) <<< CF;
                r_sin <= '0;
            end
            if ((r_state == S_DC_WAIT) && w_div_stat.done) begin
                r_cos <= w_coef_c;
            end
            if ((r_state == S_DS_WAIT) && w_div_stat.done) begin
                r_sin <= w_coef_s;
            end
        end

        if (w_accept) begin
            r_action <= i_action;
            r_p      <= i_first_value;
            r_q      <= i_second_value;
        end

        // products arrive in the cycle after their operands
        if (r_state == S_MUL) begin
            case (r_k)
                3'd1: r_acc <= w_prod_ext;
                3'd2: r_t0  <= r_acc + w_prod_ext;
                3'd3: r_acc <= w_prod_ext;
                3'd4: r_acc <= r_acc - w_prod_ext;
                default: r_acc <= r_acc;
            endcase
        end

        if ((r_state == S_SQ_WAIT) && w_sq_stat.done) begin
            r_h <= w_root;
        end

        if (r_state == S_DONE) begin
            if (r_action) begin
                r_first  <= w_scale0[DW-1:0];
                r_second <= w_scale1[DW-1:0];
                r_degen  <= 1'b0;
                r_sat    <= w_scale0[DW] | w_scale1[DW];
            end else if (w_zero_pair) begin
                r_first  <= '0;
                r_second <= '0;
                r_degen  <= 1'b1;
                r_sat    <= 1'b0;
            end else begin
                // hypotenuse clipped to the largest positive value
                r_first  <= r_h[DW-1] ? DATA_MAX : r_h;
                r_second <= '0;
                r_degen  <= 1'b0;
                r_sat    <= r_h[DW-1];
            end
        end
    end

    assign o_in_ready      = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_first_result  = r_first;
    assign o_second_result = r_second;
    assign o_degenerate    = r_degen;
    assign o_saturated     = r_sat;

endmodule

`default_nettype wire

FILE: rtl/gru_checker.sv
`default_nettype none
`include "givens_rotation_unit_macros.svh"

module gru_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [DATA_WIDTH-1:0] o_first_result,
    input logic signed [DATA_WIDTH-1:0] o_second_result,
    input logic                         o_degenerate,
    input logic                         o_saturated
);

    // no new beat while a result waits
    `GRU_ASSERT_SAME(a_ready_low_on_result, o_out_valid, !o_in_ready)

    // an accepted beat closes the input until its result is out
    `GRU_ASSERT_NEXT(a_accept_closes_input, i_in_valid && o_in_ready, !o_in_ready)

    // a degenerate set-up returns an all-zero pair
    `GRU_ASSERT_SAME(a_degenerate_zero, o_out_valid && o_degenerate,
        (o_first_result == '0) && (o_second_result == '0) && !o_saturated)

    // stalled result holds
    `GRU_ASSERT_NEXT(a_result_holds, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_first_result) && $stable(o_second_result))

endmodule

bind givens_rotation_unit gru_checker #(.DATA_WIDTH(DATA_WIDTH)) u_gru_checker (.*);

`default_nettype wire

FILE: tb/givens_rotation_unit_tb.sv
`timescale 1ns / 1ps

module givens_rotation_unit_tb;

    localparam int DW       = 32;
    localparam int CFB      = 30;
    localparam int N_RANDOM = 1525;
    localparam int HOLD_LEN = 400;

    // action codes of an input beat
    localparam bit ACT_SETUP  = 1'b0;
    localparam bit ACT_ROTATE = 1'b1;

    typedef struct {
        bit              act;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;
    } t_pair_item;

    typedef struct {
        logic [DW-1:0]   r0;
        logic [DW-1:0]   r1;
        logic            degen;
        logic            sat;
    } t_rot_result;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    logic            i_action;
    logic [DW-1:0]   i_first_value;
    logic [DW-1:0]   i_second_value;
    logic            o_out_valid;
    logic            i_out_ready;
    logic [DW-1:0]   o_first_result;
    logic [DW-1:0]   o_second_result;
    logic            o_degenerate;
    logic            o_saturated;

    givens_rotation_unit #(
        .DATA_WIDTH    (DW),
        .COEF_FRAC_BITS(CFB)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_first_result (o_first_result),
        .o_second_result(o_second_result),
        .o_degenerate   (o_degenerate),
        .o_saturated    (o_saturated)
    );

    // clock: 12 ns period
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    t_pair_item  pending_pairs[$];
    t_rot_result expected_results[$];

    // predictor copy of the stored rotation, Q1.30
    longint cos_q = longint'(1) << CFB;
    longint sin_q = 0;

    int  sent_cnt  = 0;
    int  acc_cnt   = 0;
    int  got_cnt   = 0;
    int  err_cnt   = 0;
    int  n_setup   = 0;
    int  n_rotate  = 0;
    int  n_degen   = 0;
    int  n_sat     = 0;
    int  hold_cnt  = 0;
    bit  hold_done = 0;
    bit  stim_done = 0;

    // ---------------------------------------------------------------
    // fixed-point helpers for the predictor
    // ---------------------------------------------------------------

    // square root of a 64-bit value, rounded to nearest
    function automatic longint unsigned root_nearest(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned rem;
        res  = 0;
        bitv = 64'd1 << 62;
        rem  = n;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (rem > res) res = res + 1;
        return res;
    endfunction

    // clip a sign/magnitude pair into the signed data range
    function automatic logic [DW-1:0] clip_to_data(bit neg, longint unsigned mag,
                                                   ref logic sat);
        longint unsigned lim_neg;
        longint unsigned lim_pos;
        longint unsigned v;
        lim_neg = 64'd1 << (DW - 1);
        lim_pos = lim_neg - 1;
        if (neg) begin
            if (mag > lim_neg) begin
                mag = lim_neg;
                sat = 1'b1;
            end
            v = 64'd0 - mag;
        end else begin
            if (mag > lim_pos) begin
                mag = lim_pos;
                sat = 1'b1;
            end
            v = mag;
        end
        return v[DW-1:0];
    endfunction

    // drop the coefficient fraction, rounding half away from zero
    function automatic logic [DW-1:0] descale(longint t, ref logic sat);
        longint unsigned m;
        m = (t < 0) ? (64'd0 - longint'(t)) : longint'(t);
        m = (m + (64'd1 << (CFB - 1))) >> CFB;
        return clip_to_data(t < 0, m, sat);
    endfunction

    // coefficient = v / h in Q1.30, rounded, sign of v
    function automatic longint coef_from(longint v, longint unsigned h);
        longint unsigned m;
        longint unsigned q;
        m = (v < 0) ? longint'(-v) : longint'(v);
        q = ((m << CFB) + (h >> 1)) / h;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    // expected result of one beat, updating the stored rotation
    function automatic t_rot_result rotate_or_setup(t_pair_item it);
        t_rot_result     r;
        longint          p;
        longint          q;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned h;
        longint          t0;
        longint          t1;
        p       = longint'($signed(it.a));
        q       = longint'($signed(it.b));
        r.sat   = 1'b0;
        r.degen = 1'b0;
        r.r1    = '0;
        if (it.act == ACT_SETUP) begin
            ma = (p < 0) ? longint'(-p) : longint'(p);
            mb = (q < 0) ? longint'(-q) : longint'(q);
            if (ma == 0 && mb == 0) begin
                // both zero: identity rotation, flagged
                cos_q   = longint'(1) << CFB;
                sin_q   = 0;
                r.degen = 1'b1;
                r.r0    = '0;
            end else begin
                h     = root_nearest(ma * ma + mb * mb);
                cos_q = coef_from(p, h);
                sin_q = coef_from(q, h);
                r.r0  = clip_to_data(1'b0, h, r.sat);
            end
        end else begin
            t0   = cos_q * p + sin_q * q;
            t1   = cos_q * q - sin_q * p;
            r.r0 = descale(t0, r.sat);
            r.r1 = descale(t1, r.sat);
        end
        return r;
    endfunction

    // mix of full-range, small, tiny, extreme and zero values
    function automatic logic [DW-1:0] pick_value();
        logic [DW-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2:    v = DW'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
            3:    v = DW'(int'($urandom_range(0, 32)) - 16);
            4: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h8000_0001;
                    default: v = 32'h0001_0000;
                endcase
            end
            default: v = '0;
        endcase
        return v;
    endfunction

    task automatic queue_pair(bit act, logic [DW-1:0] a, logic [DW-1:0] b);
        t_pair_item it;
        it.act = act;
        it.a   = a;
        it.b   = b;
        pending_pairs.push_back(it);
    endtask

    // idle pattern follows the number of accepted beats:
    // sender 28% / receiver 87%, then swapped, then no idling
    function automatic bit sender_idles();
        if (acc_cnt < 520)  return ($urandom_range(0, 99) < 28);
        if (acc_cnt < 1040) return ($urandom_range(0, 99) < 87);
        return 1'b0;
    endfunction

    function automatic bit receiver_idles();
        if (acc_cnt < 520)  return ($urandom_range(0, 99) < 87);
        if (acc_cnt < 1040) return ($urandom_range(0, 99) < 28);
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // driver: new beat at the falling edge once the previous one is taken
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && acc_cnt != sent_cnt) begin
                // beat still on offer, hold it
            end else if (pending_pairs.size() != 0 && !sender_idles()) begin
                t_pair_item it;
                it = pending_pairs.pop_front();
                i_action       <= it.act;
                i_first_value  <= it.a;
                i_second_value <= it.b;
                i_in_valid     <= 1'b1;
                sent_cnt       <= sent_cnt + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // accept side: predict at the edge where the input beat is taken
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            t_pair_item it;
            it.act = i_action;
            it.a   = i_first_value;
            it.b   = i_second_value;
            if (it.act == ACT_SETUP) n_setup++;
            else n_rotate++;
            expected_results.push_back(rotate_or_setup(it));
            acc_cnt++;
        end
    end

    // ---------------------------------------------------------------
    // receiver ready, with one long hold-off to back up the input side
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && acc_cnt >= 200) begin
                hold_done   <= 1'b1;
                hold_cnt    <= HOLD_LEN;
                i_out_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt    <= hold_cnt - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !receiver_idles();
            end
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_rot_result e;
            got_cnt++;
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: r0=%h r1=%h", o_first_result,
                       o_second_result);
                err_cnt++;
            end else begin
                e = expected_results.pop_front();
                if (o_degenerate) n_degen++;
                if (o_saturated) n_sat++;
                if (o_first_result !== e.r0) begin
                    $error("first_result: expected %h, got %h", e.r0, o_first_result);
                    err_cnt++;
                end
                if (o_second_result !== e.r1) begin
                    $error("second_result: expected %h, got %h", e.r1, o_second_result);
                    err_cnt++;
                end
                if (o_degenerate !== e.degen) begin
                    $error("degenerate: expected %b, got %b", e.degen, o_degenerate);
                    err_cnt++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated: expected %b, got %b", e.sat, o_saturated);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        int n;
        int k;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_out_ready    = 1'b0;
        i_action       = ACT_SETUP;
        i_first_value  = '0;
        i_second_value = '0;

        // rotate before any set-up: identity
        queue_pair(ACT_ROTATE, 32'h0003_8000, 32'hfffe_0000);
        queue_pair(ACT_ROTATE, 32'h8000_0000, 32'h7fff_ffff);
        // zero pair: degenerate, then identity rotation
        queue_pair(ACT_SETUP,  32'h0000_0000, 32'h0000_0000);
        queue_pair(ACT_ROTATE, 32'h1234_5678, 32'h8765_4321);
        // ordinary 3-4-5 triangle, with a column whose top is zero
        queue_pair(ACT_SETUP,  32'h0003_0000, 32'h0004_0000);
        queue_pair(ACT_ROTATE, 32'h0003_0000, 32'h0004_0000);
        queue_pair(ACT_ROTATE, 32'h0000_0000, 32'h0001_0000);
        // negative operands
        queue_pair(ACT_SETUP,  32'hfffd_0000, 32'h0004_0000);
        queue_pair(ACT_ROTATE, 32'h0000_0000, 32'hffff_0000);
        // hypotenuse past the data range
        queue_pair(ACT_SETUP,  32'h8000_0000, 32'h8000_0000);
        queue_pair(ACT_SETUP,  32'h7fff_ffff, 32'h7fff_ffff);
        // 45 degrees, then rotation overflow in both directions
        queue_pair(ACT_ROTATE, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_pair(ACT_ROTATE, 32'h8000_0000, 32'h8000_0000);
        queue_pair(ACT_ROTATE, 32'h8000_0000, 32'h7fff_ffff);
        // one operand zero, either side
        queue_pair(ACT_SETUP,  32'h0000_0000, 32'h8000_0000);
        queue_pair(ACT_ROTATE, 32'h7fff_ffff, 32'h8000_0000);
        queue_pair(ACT_SETUP,  32'h7fff_ffff, 32'h0000_0000);
        queue_pair(ACT_ROTATE, 32'hffff_ffff, 32'h0000_0001);
        // smallest nonzero pairs
        queue_pair(ACT_SETUP,  32'h0000_0001, 32'hffff_ffff);
        queue_pair(ACT_ROTATE, 32'h0000_0001, 32'h0000_0001);

        // random part: a set-up followed by a short run of rotations
        n = 0;
        while (n < N_RANDOM) begin
            if ($urandom_range(0, 19) == 0)
                queue_pair(ACT_SETUP, '0, '0);
            else
                queue_pair(ACT_SETUP, pick_value(), pick_value());
            n++;
            k = $urandom_range(0, 6);
            repeat (k) begin
                queue_pair(ACT_ROTATE, pick_value(), pick_value());
                n++;
            end
        end
        n = n + 20;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_pairs.size() == 0 && acc_cnt == sent_cnt && !i_in_valid);
        stim_done = 1'b1;
        wait (expected_results.size() == 0);
        repeat (200) @(posedge i_clk);

        $display("covered %0d set-up and %0d rotate beats, %0d degenerate, %0d clipped",
                 n_setup, n_rotate, n_degen, n_sat);
        $display("idle patterns on both sides plus a %0d-cycle receiver hold-off", HOLD_LEN);
        if (err_cnt == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("timeout: %0d of %0d results received", got_cnt, acc_cnt);
        $display("status: fail");
        $finish;
    end

endmodule
